// ===== hw/rtl/spbm_pkg.sv =====
// Shared types, constants and index arithmetic for the segment pair bit matrix.
package spbm_pkg;

  // Fixed field widths.
  localparam int PT_W        = 5;   // point index and point count
  localparam int CFG_W       = 5;   // configuration data
  localparam int BIT_W       = 3;   // bit within a byte
  localparam int BYTE_ADDR_W = 10;  // byte address on the result port
  localparam int TRI_W       = 2 * PT_W + 1;

  localparam logic [CFG_W-1:0] NUM_POINTS_RESET = 5'd16;

  // Command codes.
  localparam logic CMD_MARK  = 1'b0;
  localparam logic CMD_CHECK = 1'b1;

  typedef enum logic [2:0] {
    S_CLEAR,
    S_IDLE,
    S_SEG,
    S_LOC,
    S_RD,
    S_WB
  } spbm_state_t;

  // Triangular index of segment (lo, hi) among all segments of n points.
  // (2n - lo) and (lo - 1) never share parity, so the halving is exact.
  function automatic logic [TRI_W-1:0] tri_idx(
    input logic [PT_W-1:0] n,
    input logic [PT_W-1:0] lo,
    input logic [PT_W-1:0] hi
  );
    logic [PT_W:0]    two_n_lo;
    logic [TRI_W-1:0] prod;
    two_n_lo = {n, 1'b0} - {1'b0, lo};
    prod     = TRI_W'(two_n_lo) * TRI_W'(lo - PT_W'(1));
    return (prod >> 1) + TRI_W'(hi) - TRI_W'(lo);
  endfunction

endpackage

// ===== hw/rtl/segment_pair_bit_matrix_unit.sv =====
// Segment pair bit matrix: pair index arithmetic and a byte-wide bit store.
//
// Usage. A transaction enters on start with busy low, carrying a command (mark or
// check) and two segments, each named by two point indices 1..num_points. The
// segments are ordered, each gets a triangular index, and from the two a pair
// location is formed; its byte address and bit position come back on the
// result ports. Mark sets the stored bit; check returns it on out_intersects.
// Requests with an endpoint out of range, a degenerate segment, two identical
// segments, or a num_points register outside 2..MAX_POINTS are refused:
// out_bad_request is set, the other result fields are zero, and the store is
// left alone.
// Timing. A good transaction passes through segment indices, pair location
// multiply, memory read and write-back, and its result is registered onto the
// ports at the end of write-back; busy stays high through those steps, so no
// new transaction enters before the last one is through. The read-modify-write
// of the byte store follows the two multiply stages. A refused transaction
// answers in the next cycle and leaves busy low. Each result is shown for
// exactly one cycle with out_valid; the receiver cannot stall it. After reset
// the store is swept to zero, one byte a cycle, keeping busy high until all
// STORE_BYTES bytes (893 at the default size) are clear. The user must write
// num_points through cfg_we/cfg_wdata only while the block is idle (not enforced).
module segment_pair_bit_matrix_unit #(
  parameter int MAX_POINTS = 16
) (
  input  logic                     clk,
  input  logic                     rst_n,
  // Request channel
  input  logic                     start,
  output logic                     busy,
  input  logic                     in_command,
  input  logic [spbm_pkg::PT_W-1:0] in_first_seg_end_a,
  input  logic [spbm_pkg::PT_W-1:0] in_first_seg_end_b,
  input  logic [spbm_pkg::PT_W-1:0] in_second_seg_end_a,
  input  logic [spbm_pkg::PT_W-1:0] in_second_seg_end_b,
  // Configuration
  input  logic                     cfg_we,
  input  logic [spbm_pkg::CFG_W-1:0] cfg_wdata,
  // Result channel
  output logic                     out_valid,
  output logic                     out_intersects,
  output logic [spbm_pkg::BYTE_ADDR_W-1:0] out_byte_address,
  output logic [spbm_pkg::BIT_W-1:0] out_bit_position,
  output logic                     out_bad_request
);
  import spbm_pkg::*;

  // Sizes that follow from the largest point count.
  localparam int LINE_COUNT  = (MAX_POINTS * (MAX_POINTS - 1)) / 2;
  localparam int PAIR_COUNT  = (LINE_COUNT * (LINE_COUNT - 1)) / 2;
  localparam int STORE_BYTES = (PAIR_COUNT + 7) / 8;
  localparam int ADDR_W      = (STORE_BYTES > 1) ? $clog2(STORE_BYTES) : 1;
  localparam int LOC_W       = ADDR_W + BIT_W;
  localparam int SEG_W       = $clog2(LINE_COUNT + 1);
  localparam int PROD_W      = 2 * SEG_W + 1;

  localparam logic [PT_W:0]     NP_MAX     = (PT_W + 1)'(MAX_POINTS);
  localparam logic [ADDR_W-1:0] CLEAR_LAST = ADDR_W'(STORE_BYTES - 1);

  // Byte store, cleared by a sweep after reset.
  logic [7:0] pair_bits [STORE_BYTES];

  spbm_state_t state_r, state_nxt;
  logic [ADDR_W-1:0] clr_r, clr_nxt;
  logic [CFG_W-1:0]  num_points_r;

  // Per-transaction registers.
  logic              cmd_r;
  logic [PT_W-1:0]   mlo_r, mhi_r, jlo_r, jhi_r;
  logic [SEG_W-1:0]  lines_r, minor_r, major_r;
  logic [LOC_W-1:0]  loc_r;
  logic [7:0]        rd_data_r;

  // Result registers.
  logic              out_valid_r, out_valid_nxt;
  logic              out_intersects_r, out_intersects_nxt;
  logic [ADDR_W-1:0] out_byte_address_r, out_byte_address_nxt;
  logic [BIT_W-1:0]  out_bit_position_r, out_bit_position_nxt;
  logic              out_bad_request_r, out_bad_request_nxt;

  // Memory port controls.
  logic              mem_we, mem_re;
  logic [ADDR_W-1:0] mem_waddr;
  logic [7:0]        mem_wdata;

  // Request decode: endpoint ordering, validity and segment ordering.
  logic [PT_W-1:0]     lo1, hi1, lo2, hi2;
  logic                minor_first, req_bad, accept;
  logic [2*PT_W-1:0]   n_sq;
  logic [SEG_W-1:0]    lines_calc;
  logic [PROD_W-1:0]   loc_prod, loc_calc;
  logic [ADDR_W-1:0]   byte_addr;
  logic [BIT_W-1:0]    bit_pos;

  function automatic logic end_ok(input logic [PT_W-1:0] n, input logic [PT_W-1:0] p);
    return (p != '0) && (p <= n);
  endfunction

  always_comb begin
    lo1 = (in_first_seg_end_a < in_first_seg_end_b) ? in_first_seg_end_a : in_first_seg_end_b;
    hi1 = (in_first_seg_end_a < in_first_seg_end_b) ? in_first_seg_end_b : in_first_seg_end_a;
    lo2 = (in_second_seg_end_a < in_second_seg_end_b) ? in_second_seg_end_a
                                                       : in_second_seg_end_b;
    hi2 = (in_second_seg_end_a < in_second_seg_end_b) ? in_second_seg_end_b
                                                       : in_second_seg_end_a;
    minor_first = (lo1 < lo2) || ((lo1 == lo2) && (hi1 < hi2));
    req_bad = (num_points_r < PT_W'(2)) || ({1'b0, num_points_r} > NP_MAX) ||
              !end_ok(num_points_r, in_first_seg_end_a) ||
              !end_ok(num_points_r, in_first_seg_end_b) ||
              !end_ok(num_points_r, in_second_seg_end_a) ||
              !end_ok(num_points_r, in_second_seg_end_b) ||
              (lo1 == hi1) || (lo2 == hi2) || ((lo1 == lo2) && (hi1 == hi2));
    n_sq       = (2*PT_W)'(num_points_r) * (2*PT_W)'(num_points_r);
    lines_calc = SEG_W'((n_sq - (2*PT_W)'(num_points_r)) >> 1);
  end

  assign accept = start && !busy;

  // Pair location: (2L - minor)(minor - 1)/2 + major - minor - 1.
  // The two factors never share parity, so the halving is exact.
  always_comb begin
    loc_prod = PROD_W'({lines_r, 1'b0} - {1'b0, minor_r}) * PROD_W'(minor_r - SEG_W'(1));
    loc_calc = (loc_prod >> 1) + PROD_W'(major_r) - PROD_W'(minor_r) - PROD_W'(1);
  end

  assign byte_addr = loc_r[LOC_W-1:BIT_W];
  assign bit_pos   = loc_r[BIT_W-1:0];

  // Sequencer: next state, memory port and result registers.
  always_comb begin
    state_nxt            = state_r;
    clr_nxt              = clr_r;
    mem_we               = 1'b0;
    mem_re               = 1'b0;
    mem_waddr            = byte_addr;
    mem_wdata            = rd_data_r | (8'(1) << bit_pos);
    out_valid_nxt        = 1'b0;
    out_intersects_nxt   = 1'b0;
    out_byte_address_nxt = '0;
    out_bit_position_nxt = '0;
    out_bad_request_nxt  = 1'b0;
    case (state_r)
      S_CLEAR: begin
        mem_we    = 1'b1;
        mem_waddr = clr_r;
        mem_wdata = 8'h00;
        clr_nxt   = clr_r + ADDR_W'(1);
        if (clr_r == CLEAR_LAST) begin
          state_nxt = S_IDLE;
        end
      end
      S_IDLE: begin
        if (accept) begin
          if (req_bad) begin
            out_valid_nxt       = 1'b1;
            out_bad_request_nxt = 1'b1;
          end else begin
            state_nxt = S_SEG;
          end
        end
      end
      S_SEG: begin
        state_nxt = S_LOC;
      end
      S_LOC: begin
        state_nxt = S_RD;
      end
      S_RD: begin
        mem_re    = 1'b1;
        state_nxt = S_WB;
      end
      S_WB: begin
        mem_we               = (cmd_r == CMD_MARK);
        out_valid_nxt        = 1'b1;
        out_intersects_nxt   = (cmd_r == CMD_CHECK) ? rd_data_r[bit_pos] : 1'b0;
        out_byte_address_nxt = byte_addr;
        out_bit_position_nxt = bit_pos;
        state_nxt            = S_IDLE;
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  // Control state.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r      <= S_CLEAR;
      clr_r        <= '0;
      num_points_r <= NUM_POINTS_RESET;
      out_valid_r  <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      clr_r       <= clr_nxt;
      out_valid_r <= out_valid_nxt;
      if (cfg_we) begin
        num_points_r <= cfg_wdata;
      end
    end
  end

  // Payload registers.
  always_ff @(posedge clk) begin
    out_intersects_r   <= out_intersects_nxt;
    out_byte_address_r <= out_byte_address_nxt;
    out_bit_position_r <= out_bit_position_nxt;
    out_bad_request_r  <= out_bad_request_nxt;
    if (state_r == S_IDLE && accept) begin
      cmd_r   <= in_command;
      lines_r <= lines_calc;
      mlo_r   <= minor_first ? lo1 : lo2;
      mhi_r   <= minor_first ? hi1 : hi2;
      jlo_r   <= minor_first ? lo2 : lo1;
      jhi_r   <= minor_first ? hi2 : hi1;
    end
    if (state_r == S_SEG) begin
      minor_r <= SEG_W'(tri_idx(num_points_r, mlo_r, mhi_r));
      major_r <= SEG_W'(tri_idx(num_points_r, jlo_r, jhi_r));
    end
    if (state_r == S_LOC) begin
      loc_r <= LOC_W'(loc_calc);
    end
  end

  // Byte store with a registered read port.
  always_ff @(posedge clk) begin
    if (mem_we) begin
      pair_bits[mem_waddr] <= mem_wdata;
    end
    if (mem_re) begin
      rd_data_r <= pair_bits[byte_addr];
    end
  end

  assign busy             = (state_r != S_IDLE);
  assign out_valid        = out_valid_r;
  assign out_intersects   = out_intersects_r;
  // The result port carries the low ten bits of the byte address.
  assign out_byte_address = BYTE_ADDR_W'(out_byte_address_r);
  assign out_bit_position = out_bit_position_r;
  assign out_bad_request  = out_bad_request_r;

`ifndef SYNTHESIS
  // The store is written only by the clearing sweep or by a mark write-back.
  a_write_source: assert property (@(posedge clk) disable iff (!rst_n)
    mem_we |-> (state_r == S_CLEAR) || (state_r == S_WB && cmd_r == CMD_MARK))
    else $error("byte store written outside sweep or mark write-back");

  // A good result always comes from a write-back step.
  a_good_from_wb: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && !out_bad_request_r) |-> ($past(state_r) == S_WB))
    else $error("good result without a write-back step");

  // A refused transaction reports zero location and no hit.
  a_bad_zero: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && out_bad_request_r) |->
      (!out_intersects_r && out_byte_address_r == '0 && out_bit_position_r == '0))
    else $error("refused transaction carries nonzero fields");

  // A good transaction enters the index pipeline right after acceptance.
  a_accept_seg: assert property (@(posedge clk) disable iff (!rst_n)
    (accept && !req_bad) |=> (state_r == S_SEG))
    else $error("accepted transaction did not enter index stage");
`endif

endmodule

// ===== test/tb_segment_pair_bit_matrix_unit.sv =====
// Self-checking testbench for the segment pair bit matrix unit, directed and random.
module tb_segment_pair_bit_matrix_unit;
  import spbm_pkg::*;

  localparam int MAX_PTS     = 16;
  localparam int LINE_COUNT  = (MAX_PTS * (MAX_PTS - 1)) / 2;
  localparam int PAIR_COUNT  = (LINE_COUNT * (LINE_COUNT - 1)) / 2;
  localparam int STORE_BYTES = (PAIR_COUNT + 7) / 8;
  localparam int ADDR_W      = (STORE_BYTES > 1) ? $clog2(STORE_BYTES) : 1;
  localparam int IDLE_PCT    = 15;
  // The clearing sweep after reset keeps busy high until all STORE_BYTES bytes are clear.
  localparam int STALL_LIMIT = 4 * STORE_BYTES + 1000;
  localparam int MARK_KEEP   = 32;

  typedef struct {
    logic              intersects;
    logic [ADDR_W-1:0] byte_address;
    logic [BIT_W-1:0]  bit_position;
    logic              bad_request;
  } pair_result_t;

  // Holds its own copy of the bit store and num_points, predicts each
  // transaction in order and compares every result with the oldest prediction.
  class pair_matrix_board;
    logic [7:0]       pair_bits [STORE_BYTES];
    logic [CFG_W-1:0] num_points;
    pair_result_t     expected_q [$];
    int               errors;

    function new();
      foreach (pair_bits[i]) pair_bits[i] = 8'h00;
      num_points = NUM_POINTS_RESET;
      errors = 0;
    endfunction

    function void set_points(logic [CFG_W-1:0] value);
      num_points = value;
    endfunction

    function int pending();
      return expected_q.size();
    endfunction

    function void note_request(logic cmd, logic [PT_W-1:0] a1, logic [PT_W-1:0] b1,
                               logic [PT_W-1:0] a2, logic [PT_W-1:0] b2);
      pair_result_t r;
      int n, lo1, hi1, lo2, hi2, mlo, mhi, jlo, jhi;
      int lines, minor, major, loc, byte_idx, bit_idx;
      bit bad;
      n   = num_points;
      lo1 = (a1 < b1) ? a1 : b1;
      hi1 = (a1 < b1) ? b1 : a1;
      lo2 = (a2 < b2) ? a2 : b2;
      hi2 = (a2 < b2) ? b2 : a2;
      r.intersects   = 1'b0;
      r.byte_address = '0;
      r.bit_position = '0;
      bad = (n < 2) || (n > MAX_PTS);
      bad = bad || a1 < 1 || a1 > n || b1 < 1 || b1 > n;
      bad = bad || a2 < 1 || a2 > n || b2 < 1 || b2 > n;
      bad = bad || lo1 == hi1 || lo2 == hi2 || (lo1 == lo2 && hi1 == hi2);
      if (!bad) begin
        // The segment with the smaller (low, high) key is the minor one.
        if (lo1 < lo2 || (lo1 == lo2 && hi1 < hi2)) begin
          mlo = lo1; mhi = hi1; jlo = lo2; jhi = hi2;
        end else begin
          mlo = lo2; mhi = hi2; jlo = lo1; jhi = hi1;
        end
        lines = (n * n - n) / 2;
        minor = ((2 * n - mlo) * (mlo - 1)) / 2 + mhi - mlo;
        major = ((2 * n - jlo) * (jlo - 1)) / 2 + jhi - jlo;
        loc   = ((2 * lines - minor) * (minor - 1)) / 2 + major - minor - 1;
        byte_idx = loc / 8;
        bit_idx  = loc % 8;
        if (byte_idx >= STORE_BYTES) begin
          bad = 1'b1;
        end else begin
          if (cmd == CMD_MARK) pair_bits[byte_idx][bit_idx] = 1'b1;
          else r.intersects = pair_bits[byte_idx][bit_idx];
          r.byte_address = ADDR_W'(byte_idx);
          r.bit_position = BIT_W'(bit_idx);
        end
      end
      r.bad_request = bad;
      expected_q.push_back(r);
    endfunction

    function void check_result(pair_result_t got);
      pair_result_t want;
      if (expected_q.size() == 0) begin
        $display("%0t: unexpected result: intersects %0d byte %0d bit %0d bad %0d",
                 $time, got.intersects, got.byte_address, got.bit_position,
                 got.bad_request);
        errors++;
        return;
      end
      want = expected_q.pop_front();
      if (got.intersects !== want.intersects) begin
        $display("%0t: intersects expected %0d actual %0d",
                 $time, want.intersects, got.intersects);
        errors++;
      end
      if (got.byte_address !== want.byte_address) begin
        $display("%0t: byte_address expected %0d actual %0d",
                 $time, want.byte_address, got.byte_address);
        errors++;
      end
      if (got.bit_position !== want.bit_position) begin
        $display("%0t: bit_position expected %0d actual %0d",
                 $time, want.bit_position, got.bit_position);
        errors++;
      end
      if (got.bad_request !== want.bad_request) begin
        $display("%0t: bad_request expected %0d actual %0d",
                 $time, want.bad_request, got.bad_request);
        errors++;
      end
    endfunction
  endclass

  logic              clk = 1'b0;
  logic              rst_n = 1'b0;
  logic              start = 1'b0;
  logic              busy;
  logic              in_command = CMD_MARK;
  logic [PT_W-1:0]   in_first_seg_end_a = '0;
  logic [PT_W-1:0]   in_first_seg_end_b = '0;
  logic [PT_W-1:0]   in_second_seg_end_a = '0;
  logic [PT_W-1:0]   in_second_seg_end_b = '0;
  logic              cfg_we = 1'b0;
  logic [CFG_W-1:0]  cfg_wdata = '0;
  logic              out_valid;
  logic              out_intersects;
  logic [ADDR_W-1:0] out_byte_address;
  logic [BIT_W-1:0]  out_bit_position;
  logic              out_bad_request;

  pair_matrix_board board = new();
  logic [4*PT_W-1:0] marked_q [$];   // recently marked pairs, replayed as checks
  int                requests_sent = 0;
  int                stall_cycles = 0;

  segment_pair_bit_matrix_unit #(.MAX_POINTS(MAX_PTS)) u_dut (
    .clk                (clk),
    .rst_n              (rst_n),
    .start              (start),
    .busy               (busy),
    .in_command         (in_command),
    .in_first_seg_end_a (in_first_seg_end_a),
    .in_first_seg_end_b (in_first_seg_end_b),
    .in_second_seg_end_a(in_second_seg_end_a),
    .in_second_seg_end_b(in_second_seg_end_b),
    .cfg_we             (cfg_we),
    .cfg_wdata          (cfg_wdata),
    .out_valid          (out_valid),
    .out_intersects     (out_intersects),
    .out_byte_address   (out_byte_address),
    .out_bit_position   (out_bit_position),
    .out_bad_request    (out_bad_request)
  );

  initial begin
    forever #2 clk = ~clk;
  end

  // Results cannot be held off, so every strobed cycle is one transaction.
  always @(posedge clk) begin
    pair_result_t got;
    if (rst_n && out_valid) begin
      got.intersects   = out_intersects;
      got.byte_address = out_byte_address;
      got.bit_position = out_bit_position;
      got.bad_request  = out_bad_request;
      board.check_result(got);
    end
  end

  always @(posedge clk) begin
    if (!rst_n || (start && !busy) || out_valid) begin
      stall_cycles <= 0;
    end else begin
      stall_cycles <= stall_cycles + 1;
      if (stall_cycles >= STALL_LIMIT) begin
        $display("tb_segment_pair_bit_matrix_unit NOT OK");
        $finish;
      end
    end
  end

  // Called at a rising edge; start stays high until the edge that takes it.
  task automatic send_request(logic cmd, logic [PT_W-1:0] a1, logic [PT_W-1:0] b1,
                              logic [PT_W-1:0] a2, logic [PT_W-1:0] b2);
    start               <= 1'b1;
    in_command          <= cmd;
    in_first_seg_end_a  <= a1;
    in_first_seg_end_b  <= b1;
    in_second_seg_end_a <= a2;
    in_second_seg_end_b <= b2;
    @(posedge clk);
    while (busy) @(posedge clk);
    board.note_request(cmd, a1, b1, a2, b2);
    requests_sent++;
    // A stretch in the middle of the run goes without any idle cycles.
    if ((requests_sent < 300 || requests_sent >= 420) &&
        $urandom_range(0, 99) < IDLE_PCT) begin
      start <= 1'b0;
      repeat ($urandom_range(1, 4)) @(posedge clk);
    end
  endtask

  task automatic pick_segment(int n, output logic [PT_W-1:0] a, output logic [PT_W-1:0] b);
    a = PT_W'($urandom_range(1, n));
    b = PT_W'($urandom_range(1, n - 1));
    if (b >= a) b++;
  endtask

  function automatic bit same_segment(logic [PT_W-1:0] a1, logic [PT_W-1:0] b1,
                                      logic [PT_W-1:0] a2, logic [PT_W-1:0] b2);
    return (a1 == a2 && b1 == b2) || (a1 == b2 && b1 == a2);
  endfunction

  task automatic random_request(int n);
    logic            cmd;
    logic [PT_W-1:0] a1, b1, a2, b2;
    int              r;
    r   = $urandom_range(0, 99);
    cmd = $urandom_range(0, 1) ? CMD_CHECK : CMD_MARK;
    if (n < 2 || n > MAX_PTS) begin
      // Every request is refused under this setting, whatever it names.
      a1 = PT_W'(r < 30 ? $urandom_range(0, 31) : $urandom_range(1, MAX_PTS));
      b1 = PT_W'($urandom_range(1, MAX_PTS));
      a2 = PT_W'($urandom_range(1, MAX_PTS));
      b2 = PT_W'(r < 50 ? $urandom_range(0, 31) : $urandom_range(1, MAX_PTS));
    end else if (r < 10) begin
      a1 = PT_W'($urandom_range(0, 31));
      b1 = PT_W'($urandom_range(0, 31));
      a2 = PT_W'($urandom_range(0, 31));
      b2 = PT_W'($urandom_range(0, 31));
    end else if (r < 14 || n == 2) begin
      // Both segments name the same pair of points.
      pick_segment(n, a1, b1);
      if (r % 2) begin a2 = b1; b2 = a1; end
      else begin a2 = a1; b2 = b1; end
    end else if (r < 17) begin
      a1 = PT_W'($urandom_range(1, n));
      b1 = a1;
      pick_segment(n, a2, b2);
    end else if (marked_q.size() > 0 && r < 50) begin
      {a1, b1, a2, b2} = marked_q[$urandom_range(0, marked_q.size() - 1)];
      cmd = CMD_CHECK;
      if (r % 2) begin
        {a1, b1, a2, b2} = {b2, a2, b1, a1};
      end
    end else begin
      pick_segment(n, a1, b1);
      do pick_segment(n, a2, b2); while (same_segment(a1, b1, a2, b2));
      if (cmd == CMD_MARK) begin
        marked_q.push_back({a1, b1, a2, b2});
        if (marked_q.size() > MARK_KEEP) void'(marked_q.pop_front());
      end
    end
    send_request(cmd, a1, b1, a2, b2);
  endtask

  // Every transaction gives a result, and its write-back is done by the time the
  // result shows, so an empty board means the block is finished; busy low confirms it.
  task automatic settle();
    start <= 1'b0;
    while (board.pending() != 0) @(posedge clk);
    repeat (8) @(posedge clk);
    while (busy) @(posedge clk);
  endtask

  task automatic write_points(int value);
    cfg_we    <= 1'b1;
    cfg_wdata <= CFG_W'(value);
    @(posedge clk);
    cfg_we    <= 1'b0;
    board.set_points(CFG_W'(value));
    marked_q.delete();
  endtask

  int phase_points [10] = '{16, 2, 3, 0, 31, 1, 17, 7, 12, 16};
  int phase_count  [10] = '{210, 20, 40, 12, 12, 8, 8, 120, 110, 90};

  initial begin
    repeat (10) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Directed part at the reset value of num_points: first and last pair,
    // reordered endpoints and segments, and each refusal that a request itself causes.
    send_request(CMD_CHECK, 5'd1,  5'd2,  5'd1,  5'd3);
    send_request(CMD_MARK,  5'd1,  5'd2,  5'd1,  5'd3);
    send_request(CMD_CHECK, 5'd3,  5'd1,  5'd2,  5'd1);
    send_request(CMD_MARK,  5'd15, 5'd16, 5'd14, 5'd16);
    send_request(CMD_CHECK, 5'd16, 5'd14, 5'd16, 5'd15);
    send_request(CMD_MARK,  5'd1,  5'd2,  5'd15, 5'd16);
    send_request(CMD_CHECK, 5'd1,  5'd16, 5'd2,  5'd3);
    send_request(CMD_MARK,  5'd2,  5'd1,  5'd1,  5'd2);
    send_request(CMD_CHECK, 5'd5,  5'd5,  5'd1,  5'd2);
    send_request(CMD_MARK,  5'd0,  5'd3,  5'd1,  5'd2);
    send_request(CMD_CHECK, 5'd1,  5'd2,  5'd3,  5'd17);
    send_request(CMD_MARK,  5'd31, 5'd31, 5'd31, 5'd31);
    send_request(CMD_CHECK, 5'd1,  5'd2,  5'd1,  5'd16);
    send_request(CMD_MARK,  5'd8,  5'd9,  5'd8,  5'd10);
    send_request(CMD_CHECK, 5'd8,  5'd10, 5'd8,  5'd9);
    send_request(CMD_CHECK, 5'd16, 5'd15, 5'd1,  5'd2);
    send_request(CMD_MARK,  5'd16, 5'd1,  5'd2,  5'd16);
    send_request(CMD_CHECK, 5'd2,  5'd16, 5'd1,  5'd16);

    // Random phases, each under its own num_points; out-of-range settings
    // are kept short since every request is refused there.
    foreach (phase_points[p]) begin
      settle();
      write_points(phase_points[p]);
      repeat (phase_count[p]) random_request(phase_points[p]);
    end

    settle();
    repeat (10) @(posedge clk);
    if (board.errors == 0 && board.pending() == 0) begin
      $display("tb_segment_pair_bit_matrix_unit OK");
    end else begin
      $display("tb_segment_pair_bit_matrix_unit NOT OK");
    end
    $finish;
  end

endmodule
